// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GNL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define GNL_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// File: rtl/gnl_pkg.sv
// shared types and constants of the grid neighbor list block
`default_nettype none

package gnl_pkg;

    localparam int ELEM_W     = 20;
    localparam int NBR_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int NSLOT      = 8;
    localparam int SLOT_W     = 3;
    localparam int REM_STEPS  = 4;
    localparam int REM_STAGES = ELEM_W / REM_STEPS;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd1;

    // one element on its way through the remainder pipeline
    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic              bad;
        logic              below;
        logic              above;
    } gnl_item_t;

endpackage

`default_nettype wire

// File: rtl/gnl_if.sv
// handshake channels of the grid neighbor list block
`default_nettype none

interface gnl_req_if import gnl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element;
    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

interface gnl_nbr_if import gnl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NBR_W-1:0] neighbor_element;
    logic             on_edge;
    logic             last;
    modport source (output valid, output neighbor_element, output on_edge, output last,
                    input ready);
    modport sink (input valid, input neighbor_element, input on_edge, input last,
                  output ready);
endinterface

interface gnl_cfg_if import gnl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gnl_rem_pipe.sv
// pipelined restoring remainder: element modulo column count, a few bits per stage
`default_nettype none

module gnl_rem_pipe import gnl_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gnl_item_t         in_item,
    input  wire logic [ELEM_W-1:0] divisor,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gnl_item_t              out_item,
    output logic [ELEM_W-1:0]      out_rem
);

    localparam int LAST = REM_STAGES - 1;

    logic [REM_STAGES-1:0] v_reg;
    logic [REM_STAGES-1:0] adv;
    logic [REM_STAGES-1:0] dn_rdy;
    gnl_item_t             item_reg [REM_STAGES];
    logic [ELEM_W-1:0]     rem_reg [REM_STAGES];

    // shift in dividend bits msb first, subtract the divisor where it fits
    function automatic logic [ELEM_W-1:0] rem_steps(
        input logic [ELEM_W-1:0]    r_in,
        input logic [REM_STEPS-1:0] bits,
        input logic [ELEM_W-1:0]    d
    );
        logic [ELEM_W:0]   trial;
        logic [ELEM_W-1:0] r;
        r = r_in;
        for (int i = REM_STEPS - 1; i >= 0; i--)
        begin
            trial = {r, bits[i]};
            if (trial >= {1'b0, d})
            begin
                r = ELEM_W'(trial - {1'b0, d});
            end
            else
            begin
                r = trial[ELEM_W-1:0];
            end
        end
        return r;
    endfunction

    for (genvar k = 0; k < REM_STAGES; k++)
    begin : g_stg
        logic              up_v;
        gnl_item_t         up_item;
        logic [ELEM_W-1:0] up_rem;

        if (k == 0)
        begin : g_first
            assign up_v    = in_valid;
            assign up_item = in_item;
            assign up_rem  = '0;
        end
        else
        begin : g_mid
            assign up_v    = v_reg[k-1];
            assign up_item = item_reg[k-1];
            assign up_rem  = rem_reg[k-1];
        end

        if (k == LAST)
        begin : g_tail
            assign dn_rdy[k] = out_ready;
        end
        else
        begin : g_body
            assign dn_rdy[k] = adv[k+1];
        end

        // a stage moves when empty or when its content moves on
        assign adv[k] = !v_reg[k] || dn_rdy[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv[k])
            begin
                v_reg[k] <= up_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && up_v)
            begin
                item_reg[k] <= up_item;
                rem_reg[k]  <= rem_steps(up_rem,
                    up_item.elem[ELEM_W-1-REM_STEPS*k -: REM_STEPS], divisor);
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[LAST];
    assign out_item  = item_reg[LAST];
    assign out_rem   = rem_reg[LAST];

endmodule

`default_nettype wire

// File: rtl/grid_neighbor_list_2d.sv
// top level of the structured 2d grid neighbor list block
// Takes one 1-based element number per request transfer and returns its neighbors,
// one per result transfer (row below, same row, row above), each with the element's
// edge flag and last set on the final one; a zero column count or an element out of
// range gives a single zero result. An element may be accepted every cycle unless the
// pipeline behind it stalls; the result port moves one neighbor per cycle unless the
// consumer stalls it, and an element has one to eight results. A request passes an
// entry register, five remainder stages (four quotient bits each), the neighbor
// serializer and the output register. Configuration writes are taken every cycle.
`default_nettype none

module grid_neighbor_list_2d import gnl_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = 1048576
) (
    input wire logic clk,
    input wire logic rst_n,
    gnl_cfg_if.sink  cfg,
    gnl_req_if.sink  request,
    gnl_nbr_if.source neighbor
);

    localparam int W = ELEM_W + 2;

    logic [ELEM_W-1:0] columns_reg;
    logic [ELEM_W-1:0] total_reg;

    logic              p0_v_reg;
    gnl_item_t         p0_item_reg;
    gnl_item_t         p0_item_next;
    logic              p0_adv;

    logic              rem_in_ready;
    logic              rem_out_valid;
    logic              rem_out_ready;
    gnl_item_t         rem_item;
    logic [ELEM_W-1:0] rem_col;

    logic              s_v_reg;
    logic [NSLOT-1:0]  s_mask_reg;
    logic [NBR_W-1:0]  s_cand_reg [NSLOT];
    logic              s_edge_reg;
    logic [NSLOT-1:0]  mask_next;
    logic [NBR_W-1:0]  cand_next [NSLOT];
    logic              edge_next;
    logic [SLOT_W-1:0] pick;
    logic              s_final;
    logic              s_emit;
    logic              s_take;

    logic              o_v_reg;
    logic [NBR_W-1:0]  o_nbr_reg;
    logic              o_edge_reg;
    logic              o_last_reg;
    logic              o_adv;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= '0;
            total_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_COLUMNS: columns_reg <= cfg.data;
                REG_TOTAL:   total_reg   <= cfg.data;
                default:     ;
            endcase
        end
    end

    // entry stage: range check and row tests
    always_comb
    begin
        p0_item_next.elem  = request.element;
        p0_item_next.bad   = (columns_reg == '0) || (request.element == '0)
                           || (request.element > total_reg)
                           || (32'(request.element) >= 32'(MAX_ELEMENTS));
        p0_item_next.below = request.element > columns_reg;
        p0_item_next.above = ({1'b0, request.element} + {1'b0, columns_reg})
                           <= {1'b0, total_reg};
    end

    assign p0_adv        = !p0_v_reg || rem_in_ready;
    assign request.ready = p0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
        end
        else if (p0_adv)
        begin
            p0_v_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p0_adv && request.valid)
        begin
            p0_item_reg <= p0_item_next;
        end
    end

    gnl_rem_pipe u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p0_v_reg),
        .in_ready  (rem_in_ready),
        .in_item   (p0_item_reg),
        .divisor   (columns_reg),
        .out_valid (rem_out_valid),
        .out_ready (rem_out_ready),
        .out_item  (rem_item),
        .out_rem   (rem_col)
    );

    // candidate list in output order, with a mask of those that exist
    always_comb
    begin
        logic [W-1:0] e;
        logic [W-1:0] c;
        logic [W-1:0] t;
        logic [W-1:0] up;
        logic [W-1:0] v [NSLOT];
        logic [NSLOT-1:0] want;
        logic first;
        logic lastc;
        logic swap;
        e     = W'(rem_item.elem);
        c     = W'(columns_reg);
        t     = W'(total_reg);
        up    = e + c;
        first = (rem_col == ELEM_W'(1)) || (columns_reg == ELEM_W'(1));
        lastc = rem_col == '0;
        // first column above: right neighbor before the one straight up
        swap  = first && !lastc;
        v[0] = e - c - W'(1);
        v[1] = e - c;
        v[2] = e - c + W'(1);
        v[3] = e - W'(1);
        v[4] = e + W'(1);
        v[5] = swap ? up + W'(1) : up - W'(1);
        v[6] = up;
        v[7] = up + W'(1);
        want[0] = rem_item.below && !first;
        want[1] = rem_item.below;
        want[2] = rem_item.below && !lastc;
        want[3] = !first;
        want[4] = !lastc;
        want[5] = rem_item.above && (swap || !first);
        want[6] = rem_item.above;
        want[7] = rem_item.above && !swap && !lastc;
        for (int i = 0; i < NSLOT; i++)
        begin
            mask_next[i] = want[i] && !rem_item.bad && (v[i] != '0) && (v[i] <= t);
            cand_next[i] = v[i][NBR_W-1:0];
        end
        edge_next = rem_item.bad || !rem_item.below || !rem_item.above
                  || (rem_col <= ELEM_W'(1));
    end

    // serializer: lowest pending slot goes out next
    always_comb
    begin
        pick = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (s_mask_reg[i])
            begin
                pick = SLOT_W'(i);
            end
        end
    end

    assign s_final       = (s_mask_reg & (s_mask_reg - NSLOT'(1))) == '0;
    assign o_adv         = !o_v_reg || neighbor.ready;
    assign s_emit        = s_v_reg && o_adv;
    assign s_take        = !s_v_reg || (s_emit && s_final);
    assign rem_out_ready = s_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_v_reg <= 1'b0;
        end
        else if (s_take)
        begin
            s_v_reg <= rem_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take && rem_out_valid)
        begin
            s_mask_reg <= mask_next;
            s_cand_reg <= cand_next;
            s_edge_reg <= edge_next;
        end
        else if (s_emit)
        begin
            s_mask_reg <= s_mask_reg & (s_mask_reg - NSLOT'(1));
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else if (o_adv)
        begin
            o_v_reg <= s_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_emit)
        begin
            o_nbr_reg  <= (s_mask_reg == '0) ? '0 : s_cand_reg[pick];
            o_edge_reg <= s_edge_reg;
            o_last_reg <= s_final;
        end
    end

    assign neighbor.valid            = o_v_reg;
    assign neighbor.neighbor_element = o_nbr_reg;
    assign neighbor.on_edge          = o_edge_reg;
    assign neighbor.last             = o_last_reg;

endmodule

`default_nettype wire

// File: rtl/gnl_checker.sv
// port-level checks of the grid neighbor list block and their binding
`default_nettype none

`include "assert_macros.svh"

module gnl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        nbr_valid,
    input wire logic        nbr_ready,
    input wire logic [20:0] nbr_element,
    input wire logic        nbr_edge,
    input wire logic        nbr_last
);

    logic       req_xfer;
    logic       end_xfer;
    logic [4:0] pend_reg;

    assign req_xfer = req_valid && req_ready;
    assign end_xfer = nbr_valid && nbr_ready && nbr_last;

    // elements accepted whose final result has not gone out yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 5'(req_xfer) - 5'(end_xfer);
        end
    end

    `GNL_ASSERT(a_stall_hold, nbr_valid && !nbr_ready |=> nbr_valid && $stable(nbr_element) && $stable(nbr_edge) && $stable(nbr_last), "result changed while stalled")
    `GNL_NEVER(a_final_unbacked, end_xfer && (pend_reg == '0), "final result without a request")
    `GNL_NEVER(a_zero_not_last, nbr_valid && !nbr_last && (nbr_element == '0), "zero neighbor before the final result")
    `GNL_NEVER(a_zero_no_edge, nbr_valid && (nbr_element == '0) && !nbr_edge && !nbr_last, "zero neighbor off the edge")
    `GNL_NEVER(a_range, nbr_valid && nbr_element[20] && (nbr_element[19:0] != '0), "neighbor number out of range")

endmodule

bind grid_neighbor_list_2d gnl_checker u_gnl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .nbr_valid   (neighbor.valid),
    .nbr_ready   (neighbor.ready),
    .nbr_element (neighbor.neighbor_element),
    .nbr_edge    (neighbor.on_edge),
    .nbr_last    (neighbor.last)
);

`default_nettype wire
